// File: rtl/core/wedc_pkg.sv
// Package for the windowed event dedup counter.
// Holds widths, table size defaults, the register address, state codes and a saturating-increment helper.
// No dependencies.
package wedc_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned PADDR_W       = 2;
	localparam int unsigned PAIR_ENTRIES  = 1024;
	localparam int unsigned TALLY_ENTRIES = 1024;
	localparam logic [DATA_W-1:0] CNT_MAX = '1;

	localparam logic [PADDR_W-1:0] REG_WINDOW = '0;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	// Saturating increment of a counter.
	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + DATA_W'(1);
	endfunction

endpackage

// File: rtl/core/wedc_if.sv
// Transfer channels of the windowed event dedup counter.
// Depends on wedc_pkg for the field width.
interface wedc_evt_if;
	logic                          valid;
	logic                          ready;
	logic signed [wedc_pkg::DATA_W-1:0] timestamp;
	logic [wedc_pkg::DATA_W-1:0]   user_id;
	logic [wedc_pkg::DATA_W-1:0]   event_id;

	modport source (output valid, timestamp, user_id, event_id, input ready);
	modport sink (input valid, timestamp, user_id, event_id, output ready);
endinterface

interface wedc_res_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [wedc_pkg::DATA_W-1:0] total_count;
	logic [wedc_pkg::DATA_W-1:0] event_tally;
	logic                        table_full;

	modport source (output valid, accepted, total_count, event_tally, table_full,
		input ready);
	modport sink (input valid, accepted, total_count, event_tally, table_full,
		output ready);
endinterface

// File: rtl/core/windowed_event_dedup_counter_unit.sv
// Windowed event dedup counter, top level.
// Usage: events come in on the evt channel (timestamp, user_id, event_id) and
// each one gives exactly one result on the res channel (accepted,
// total_count, event_tally, table_full). The window register sits on the APB
// port at byte address 0 and is to be written by the user only while the block
// is idle; the block itself does not enforce this. Lookups run through two rows
// of cells, one for (user, event) pairs and one for event tallies; a query walks
// both rows, one cell per cycle. An event is taken only in the idle state; the
// search state then waits for the length of the longer cell row before the done
// state commits and offers the result, so one event is handled at a time.
// A finished result waits in an output register; the next event is taken
// while it waits. If the receiver stalls with a result still held, the
// following result waits in the commit step and no state is updated
// until it can be handed over.
// Reset clears both fill counts, the total, the window and the output valid flag.
// Depends on wedc_pkg, wedc_if and wedc_chain.
module windowed_event_dedup_counter_unit #(
	parameter int unsigned PAIR_ENTRIES  = wedc_pkg::PAIR_ENTRIES,
	parameter int unsigned TALLY_ENTRIES = wedc_pkg::TALLY_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wedc_evt_if.sink                      evt,
	wedc_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wedc_pkg::PADDR_W-1:0]  paddr,
	input  logic [wedc_pkg::DATA_W-1:0]   pwdata,
	output logic [wedc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned DW      = wedc_pkg::DATA_W;
	localparam int unsigned P_IDX_W = $clog2(PAIR_ENTRIES);
	localparam int unsigned P_CNT_W = $clog2(PAIR_ENTRIES + 1);
	localparam int unsigned T_IDX_W = $clog2(TALLY_ENTRIES);
	localparam int unsigned T_CNT_W = $clog2(TALLY_ENTRIES + 1);
	localparam int unsigned MAX_N   =
		(PAIR_ENTRIES > TALLY_ENTRIES) ? PAIR_ENTRIES : TALLY_ENTRIES;
	localparam int unsigned WAIT_W  = $clog2(MAX_N);
	localparam logic [WAIT_W-1:0]  WAIT_LAST = WAIT_W'(MAX_N - 1);
	localparam logic [P_CNT_W-1:0] P_FULL    = P_CNT_W'(PAIR_ENTRIES);
	localparam logic [T_CNT_W-1:0] T_FULL    = T_CNT_W'(TALLY_ENTRIES);

	logic [1:0]          state_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [DW-1:0]       window_q;
	logic [DW-1:0]       ts_q;
	logic [DW-1:0]       user_q;
	logic [DW-1:0]       ev_q;
	logic [P_CNT_W-1:0]  pair_used_q;
	logic [T_CNT_W-1:0]  tally_used_q;
	logic [DW-1:0]       total_q;
	logic                out_valid_q;
	logic                out_acc_q;
	logic [DW-1:0]       out_total_q;
	logic [DW-1:0]       out_tally_q;
	logic                out_full_q;

	logic                p_hit;
	logic [DW-1:0]       p_data;
	logic [P_IDX_W-1:0]  p_idx;
	logic                t_hit;
	logic [DW-1:0]       t_data;
	logic [T_IDX_W-1:0]  t_idx;

	logic                commit;
	logic                pair_full;
	logic                tally_full;
	logic signed [DW:0]  diff;
	logic signed [DW:0]  win_ext;
	logic                want;
	logic                full;
	logic                acc;
	logic [DW-1:0]       tally_new;
	logic [DW-1:0]       tally_res;
	logic [DW-1:0]       total_new;
	logic                p_wr_en;
	logic                t_wr_en;
	logic [P_IDX_W-1:0]  p_wr_idx;
	logic [T_IDX_W-1:0]  t_wr_idx;
	logic                cfg_wr;

	// Config port: every write lands in the only register
	assign pready = 1'b1;
	assign prdata = (paddr == wedc_pkg::REG_WINDOW) ? window_q : '0;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_wr) begin
			window_q <= pwdata;
		end
	end

	// Lookup rows
	wedc_chain #(
		.ENTRIES(PAIR_ENTRIES),
		.KEY_W  (2 * DW)
	) u_pair (
		.clk       (clk),
		.arst_n    (arst_n),
		.used      (pair_used_q),
		.query     ({user_q, ev_q}),
		.wr_en     (p_wr_en),
		.wr_key_en (!p_hit),
		.wr_idx    (p_wr_idx),
		.wr_key    ({user_q, ev_q}),
		.wr_data   (ts_q),
		.hit       (p_hit),
		.data      (p_data),
		.idx       (p_idx)
	);

	wedc_chain #(
		.ENTRIES(TALLY_ENTRIES),
		.KEY_W  (DW)
	) u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.used      (tally_used_q),
		.query     (ev_q),
		.wr_en     (t_wr_en),
		.wr_key_en (!t_hit),
		.wr_idx    (t_wr_idx),
		.wr_key    (ev_q),
		.wr_data   (tally_new),
		.hit       (t_hit),
		.data      (t_data),
		.idx       (t_idx)
	);

	// Decide acceptance from the row outputs
	assign pair_full  = (pair_used_q == P_FULL);
	assign tally_full = (tally_used_q == T_FULL);
	assign diff       = $signed({ts_q[DW-1], ts_q}) - $signed({p_data[DW-1], p_data});
	assign win_ext    = $signed({window_q[DW-1], window_q});
	assign want       = p_hit ? (diff > win_ext) : !pair_full;
	assign full       = (!p_hit && pair_full) || (want && !t_hit && tally_full);
	assign acc        = want && !full;
	assign tally_new  = t_hit ? wedc_pkg::sat_inc(t_data) : DW'(1);
	assign tally_res  = acc ? tally_new : (t_hit ? t_data : '0);
	assign total_new  = acc ? wedc_pkg::sat_inc(total_q) : total_q;

	assign commit   = (state_q == wedc_pkg::ST_DONE) && (!out_valid_q || res.ready);
	assign p_wr_en  = commit && acc;
	assign t_wr_en  = commit && acc;
	assign p_wr_idx = p_hit ? p_idx : pair_used_q[P_IDX_W-1:0];
	assign t_wr_idx = t_hit ? t_idx : tally_used_q[T_IDX_W-1:0];

	assign evt.ready = (state_q == wedc_pkg::ST_IDLE);

	// Sequencer: take an event, wait for the rows, commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wedc_pkg::ST_IDLE;
			wait_q  <= '0;
		end else begin
			unique case (state_q)
				wedc_pkg::ST_IDLE: begin
					if (evt.valid) begin
						state_q <= wedc_pkg::ST_SEARCH;
						wait_q  <= '0;
					end
				end
				wedc_pkg::ST_SEARCH: begin
					if (wait_q == WAIT_LAST) begin
						state_q <= wedc_pkg::ST_DONE;
					end else begin
						wait_q <= wait_q + WAIT_W'(1);
					end
				end
				wedc_pkg::ST_DONE: begin
					if (commit) begin
						state_q <= wedc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wedc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Hold the query during the search
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			ts_q   <= evt.timestamp;
			user_q <= evt.user_id;
			ev_q   <= evt.event_id;
		end
	end

	// Advance fill counts and total on an accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_used_q  <= '0;
			tally_used_q <= '0;
			total_q      <= '0;
		end else if (commit && acc) begin
			total_q <= total_new;
			if (!p_hit) begin
				pair_used_q <= pair_used_q + P_CNT_W'(1);
			end
			if (!t_hit) begin
				tally_used_q <= tally_used_q + T_CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_acc_q   <= acc;
			out_total_q <= total_new;
			out_tally_q <= tally_res;
			out_full_q  <= full;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.accepted    = out_acc_q;
	assign res.total_count = out_total_q;
	assign res.event_tally = out_tally_q;
	assign res.table_full  = out_full_q;

endmodule

// File: rtl/core/wedc_cell.sv
// One table entry of a search chain: stored key and value, a compare against
// the broadcast query, and a link register that passes the hit to the next cell.
// Depends on wedc_pkg.
module wedc_cell #(
	parameter int unsigned KEY_W = 32,
	parameter int unsigned IDX_W = 10,
	parameter int unsigned CNT_W = 11,
	parameter int unsigned INDEX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [CNT_W-1:0]            used,
	input  logic [KEY_W-1:0]            query,
	input  logic                        hit_in,
	input  logic [wedc_pkg::DATA_W-1:0] data_in,
	input  logic [IDX_W-1:0]            idx_in,
	input  logic                        wr_en,
	input  logic                        wr_key_en,
	input  logic [IDX_W-1:0]            wr_idx,
	input  logic [KEY_W-1:0]            wr_key,
	input  logic [wedc_pkg::DATA_W-1:0] wr_data,
	output logic                        hit_out,
	output logic [wedc_pkg::DATA_W-1:0] data_out,
	output logic [IDX_W-1:0]            idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(INDEX);

	logic [KEY_W-1:0]            key_q;
	logic [wedc_pkg::DATA_W-1:0] val_q;
	logic                        hit_q;
	logic [wedc_pkg::DATA_W-1:0] link_data_q;
	logic [IDX_W-1:0]            link_idx_q;
	logic                        match;

	assign match = (MY_CNT < used) && (key_q == query);

	// Store the entry when it is addressed
	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == MY_IDX)) begin
			val_q <= wr_data;
			if (wr_key_en) begin
				key_q <= wr_key;
			end
		end
	end

	// Pass an earlier hit along, else offer this entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_in || match;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_in) begin
			link_data_q <= data_in;
			link_idx_q  <= idx_in;
		end else begin
			link_data_q <= val_q;
			link_idx_q  <= MY_IDX;
		end
	end

	assign hit_out  = hit_q;
	assign data_out = link_data_q;
	assign idx_out  = link_idx_q;

endmodule

// File: rtl/core/wedc_chain.sv
// A row of search cells forming one lookup table; the result of a query passes
// through the link register of each cell on its way to the end of the row.
// Depends on wedc_pkg and wedc_cell.
module wedc_chain #(
	parameter int unsigned ENTRIES = 1024,
	parameter int unsigned KEY_W   = 32,
	parameter int unsigned IDX_W   = $clog2(ENTRIES),
	parameter int unsigned CNT_W   = $clog2(ENTRIES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [CNT_W-1:0]            used,
	input  logic [KEY_W-1:0]            query,
	input  logic                        wr_en,
	input  logic                        wr_key_en,
	input  logic [IDX_W-1:0]            wr_idx,
	input  logic [KEY_W-1:0]            wr_key,
	input  logic [wedc_pkg::DATA_W-1:0] wr_data,
	output logic                        hit,
	output logic [wedc_pkg::DATA_W-1:0] data,
	output logic [IDX_W-1:0]            idx
);

	logic                        hit_w  [ENTRIES+1];
	logic [wedc_pkg::DATA_W-1:0] data_w [ENTRIES+1];
	logic [IDX_W-1:0]            idx_w  [ENTRIES+1];

	assign hit_w[0]  = 1'b0;
	assign data_w[0] = '0;
	assign idx_w[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		wedc_cell #(
			.KEY_W(KEY_W),
			.IDX_W(IDX_W),
			.CNT_W(CNT_W),
			.INDEX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.used      (used),
			.query     (query),
			.hit_in    (hit_w[i]),
			.data_in   (data_w[i]),
			.idx_in    (idx_w[i]),
			.wr_en     (wr_en),
			.wr_key_en (wr_key_en),
			.wr_idx    (wr_idx),
			.wr_key    (wr_key),
			.wr_data   (wr_data),
			.hit_out   (hit_w[i+1]),
			.data_out  (data_w[i+1]),
			.idx_out   (idx_w[i+1])
		);
	end

	assign hit  = hit_w[ENTRIES];
	assign data = data_w[ENTRIES];
	assign idx  = idx_w[ENTRIES];

endmodule
